/* src/rpt_pkg.sv */
// Shared types and constants for the rigid pose transform block.
// Depends on nothing; every other file in src uses it by scoped names.
`default_nettype none

package rpt_pkg;

    // Fixed-point formats
    localparam int VEC_W     = 32;               // Q16.16 vectors and positions
    localparam int COEF_FRAC = 14;               // fraction bits of quaternion and matrix
    localparam int QUAT_W    = 16;               // Q2.14 quaternion components
    localparam int MAT_W     = COEF_FRAC + 4;    // Q4.14 matrix entries
    localparam int DIFF_W    = VEC_W + 1;        // vector minus position, exact
    localparam int PROD_W    = MAT_W + DIFF_W;   // one coefficient times one component
    localparam int ACC_W     = PROD_W + 3;       // three products plus shifted position

    localparam logic [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) << COEF_FRAC;
    localparam logic [MAT_W-1:0]  MAT_ONE  = MAT_W'(1) << COEF_FRAC;

    typedef enum logic [1:0] {
        REQ_POINT     = 2'd0,
        REQ_DIR       = 2'd1,
        REQ_INV_POINT = 2'd2,
        REQ_INV_DIR   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_QUAT_W = 3'd0,
        REG_QUAT_I = 3'd1,
        REG_QUAT_J = 3'd2,
        REG_QUAT_K = 3'd3,
        REG_POS_X  = 3'd4,
        REG_POS_Y  = 3'd5,
        REG_POS_Z  = 3'd6
    } reg_idx_t;

    typedef logic signed [MAT_W-1:0] coef_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    typedef struct packed {
        logic [1:0] req_type;
        vec_t       vec_x;
        vec_t       vec_y;
        vec_t       vec_z;
    } in_t;

    typedef struct packed {
        vec_t out_x;
        vec_t out_y;
        vec_t out_z;
        logic overflow;
    } out_t;

    // Pose as seen by the datapath: row-major matrix, position, rebuild in progress
    typedef struct packed {
        coef_t [8:0] mat;
        vec_t  [2:0] pos;
        logic        busy;
    } pose_t;

endpackage

`default_nettype wire

/* src/rpt_cfg.sv */
// Pose registers and rotation matrix rebuild for the rigid pose transform.
// Depends on rpt_pkg. Products of quaternion pairs are registered, then the entries.
`default_nettype none

module rpt_cfg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data,
    output rpt_pkg::pose_t     pose
);

    localparam int PQ_W  = 2 * rpt_pkg::QUAT_W;   // quaternion product
    localparam int SUM_W = PQ_W + 1;              // sum or difference of two products
    localparam int ENT_W = PQ_W + 4;              // base + 2*sum + rounding
    localparam int RND_W = ENT_W - rpt_pkg::COEF_FRAC;

    localparam logic signed [ENT_W-1:0] ENT_ONE  = ENT_W'(1) << (2 * rpt_pkg::COEF_FRAC);
    localparam logic signed [ENT_W-1:0] ENT_HALF = ENT_W'(1) << (rpt_pkg::COEF_FRAC - 1);

    logic signed [rpt_pkg::QUAT_W-1:0] qw_reg, qi_reg, qj_reg, qk_reg;
    rpt_pkg::vec_t                     pos_reg [3];
    logic signed [PQ_W-1:0]            ii_reg, jj_reg, kk_reg, ij_reg, ik_reg, jk_reg;
    logic signed [PQ_W-1:0]            iw_reg, jw_reg, kw_reg;
    rpt_pkg::coef_t                    mat_reg  [9];
    rpt_pkg::coef_t                    mat_next [9];
    logic [1:0]                        pend_reg, pend_next;
    logic                              quat_wr;

    // base - 2*(p1 + p2) on the diagonal, otherwise 2*(p1 +/- p2); round half up, saturate
    function automatic rpt_pkg::coef_t mat_entry(
        input logic                   diag,
        input logic signed [PQ_W-1:0] p1,
        input logic signed [PQ_W-1:0] p2,
        input logic                   sub
    );
        logic signed [SUM_W-1:0] s;
        logic signed [ENT_W-1:0] t;
        logic signed [RND_W-1:0] r;
        logic                    same;
        s = sub ? (SUM_W'(p1) - SUM_W'(p2)) : (SUM_W'(p1) + SUM_W'(p2));
        if (diag) begin
            t = ENT_ONE - (ENT_W'(s) <<< 1) + ENT_HALF;
        end else begin
            t = (ENT_W'(s) <<< 1) + ENT_HALF;
        end
        r = t[ENT_W-1:rpt_pkg::COEF_FRAC];
        same = (r[RND_W-1:rpt_pkg::MAT_W-1] == {(RND_W-rpt_pkg::MAT_W+1){1'b0}})
            || (r[RND_W-1:rpt_pkg::MAT_W-1] == {(RND_W-rpt_pkg::MAT_W+1){1'b1}});
        if (same) begin
            mat_entry = r[rpt_pkg::MAT_W-1:0];
        end else if (r[RND_W-1]) begin
            mat_entry = {1'b1, {(rpt_pkg::MAT_W-1){1'b0}}};
        end else begin
            mat_entry = {1'b0, {(rpt_pkg::MAT_W-1){1'b1}}};
        end
    endfunction

    assign cfg_ready = 1'b1;

    assign quat_wr = cfg_valid && ((cfg_index == rpt_pkg::REG_QUAT_W)
        || (cfg_index == rpt_pkg::REG_QUAT_I) || (cfg_index == rpt_pkg::REG_QUAT_J)
        || (cfg_index == rpt_pkg::REG_QUAT_K));

    // Products are registered after the write, the matrix entries after the products
    assign pend_next = {pend_reg[0], quat_wr};

    always_comb begin
        mat_next[0] = mat_entry(1'b1, jj_reg, kk_reg, 1'b0);
        mat_next[1] = mat_entry(1'b0, ij_reg, kw_reg, 1'b0);
        mat_next[2] = mat_entry(1'b0, ik_reg, jw_reg, 1'b1);
        mat_next[3] = mat_entry(1'b0, ij_reg, kw_reg, 1'b1);
        mat_next[4] = mat_entry(1'b1, ii_reg, kk_reg, 1'b0);
        mat_next[5] = mat_entry(1'b0, jk_reg, iw_reg, 1'b0);
        mat_next[6] = mat_entry(1'b0, ik_reg, jw_reg, 1'b0);
        mat_next[7] = mat_entry(1'b0, jk_reg, iw_reg, 1'b1);
        mat_next[8] = mat_entry(1'b1, ii_reg, jj_reg, 1'b0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qw_reg     <= rpt_pkg::QUAT_ONE;
            qi_reg     <= '0;
            qj_reg     <= '0;
            qk_reg     <= '0;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
            pend_reg   <= '0;
            for (int e = 0; e < 9; e++) begin
                mat_reg[e] <= (e == 0 || e == 4 || e == 8) ? rpt_pkg::MAT_ONE : '0;
            end
        end else begin
            pend_reg <= pend_next;
            if (cfg_valid) begin
                case (cfg_index)
                    rpt_pkg::REG_QUAT_W: qw_reg     <= cfg_data[rpt_pkg::QUAT_W-1:0];
                    rpt_pkg::REG_QUAT_I: qi_reg     <= cfg_data[rpt_pkg::QUAT_W-1:0];
                    rpt_pkg::REG_QUAT_J: qj_reg     <= cfg_data[rpt_pkg::QUAT_W-1:0];
                    rpt_pkg::REG_QUAT_K: qk_reg     <= cfg_data[rpt_pkg::QUAT_W-1:0];
                    rpt_pkg::REG_POS_X:  pos_reg[0] <= cfg_data[rpt_pkg::VEC_W-1:0];
                    rpt_pkg::REG_POS_Y:  pos_reg[1] <= cfg_data[rpt_pkg::VEC_W-1:0];
                    rpt_pkg::REG_POS_Z:  pos_reg[2] <= cfg_data[rpt_pkg::VEC_W-1:0];
                    default: ;  // drop writes beyond the register list
                endcase
            end
            if (pend_reg[1]) begin
                for (int e = 0; e < 9; e++) begin
                    mat_reg[e] <= mat_next[e];
                end
            end
        end
    end

    // Free-running product stage; only read after a quaternion write settles
    always_ff @(posedge aclk) begin
        ii_reg <= qi_reg * qi_reg;
        jj_reg <= qj_reg * qj_reg;
        kk_reg <= qk_reg * qk_reg;
        ij_reg <= qi_reg * qj_reg;
        ik_reg <= qi_reg * qk_reg;
        jk_reg <= qj_reg * qk_reg;
        iw_reg <= qi_reg * qw_reg;
        jw_reg <= qj_reg * qw_reg;
        kw_reg <= qk_reg * qw_reg;
    end

    always_comb begin
        for (int e = 0; e < 9; e++) begin
            pose.mat[e] = mat_reg[e];
        end
        pose.pos[0] = pos_reg[0];
        pose.pos[1] = pos_reg[1];
        pose.pos[2] = pos_reg[2];
        pose.busy   = |pend_reg;
    end

endmodule

`default_nettype wire

/* src/rpt_pipe.sv */
// Four-stage vector datapath: offset and coefficient select, multiply, sum,
// round and saturate into the output register. Depends on rpt_pkg.
`default_nettype none

module rpt_pipe (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire rpt_pkg::in_t   in_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rpt_pkg::out_t       m_data,
    input  wire rpt_pkg::pose_t pose
);

    localparam int RND_W = rpt_pkg::ACC_W - rpt_pkg::COEF_FRAC;
    localparam logic signed [rpt_pkg::ACC_W-1:0] ACC_HALF =
        rpt_pkg::ACC_W'(1) << (rpt_pkg::COEF_FRAC - 1);

    // Stage valids and enables; a stage loads when it is empty or its successor loads
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic en1, en2, en3, en4;

    logic signed [rpt_pkg::DIFF_W-1:0] v1_reg   [3];
    logic signed [rpt_pkg::DIFF_W-1:0] v1_next  [3];
    rpt_pkg::coef_t                    c1_reg   [9];
    rpt_pkg::coef_t                    c1_next  [9];
    rpt_pkg::req_t                     op1_reg, op2_reg;
    logic signed [rpt_pkg::PROD_W-1:0] p2_reg   [9];
    logic signed [rpt_pkg::PROD_W-1:0] p2_next  [9];
    logic signed [rpt_pkg::ACC_W-1:0]  acc3_reg [3];
    logic signed [rpt_pkg::ACC_W-1:0]  acc3_next[3];
    rpt_pkg::out_t                     out_reg, out_next;
    rpt_pkg::req_t                     op_in;
    rpt_pkg::vec_t                     vin [3];

    assign en4      = !vld4_reg || m_ready;
    assign en3      = !vld3_reg || en4;
    assign en2      = !vld2_reg || en3;
    assign en1      = !vld1_reg || en2;
    assign in_ready = en1;

    assign op_in  = rpt_pkg::req_t'(in_data.req_type);
    assign vin[0] = in_data.vec_x;
    assign vin[1] = in_data.vec_y;
    assign vin[2] = in_data.vec_z;

    // Stage 1: subtract the position for inverse points, pick rows or columns
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (op_in == rpt_pkg::REQ_INV_POINT) begin
                v1_next[r] = rpt_pkg::DIFF_W'(vin[r]) - rpt_pkg::DIFF_W'($signed(pose.pos[r]));
            end else begin
                v1_next[r] = rpt_pkg::DIFF_W'(vin[r]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (op_in == rpt_pkg::REQ_POINT || op_in == rpt_pkg::REQ_DIR) begin
                    c1_next[r*3+c] = pose.mat[r*3+c];
                end else begin
                    c1_next[r*3+c] = pose.mat[c*3+r];
                end
            end
        end
    end

    // Stage 2: nine coefficient by component products
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            p2_next[k] = c1_reg[k] * v1_reg[k%3];
        end
    end

    // Stage 3: row sums, plus the shifted position for points
    always_comb begin
        logic signed [rpt_pkg::ACC_W-1:0] pterm;
        for (int r = 0; r < 3; r++) begin
            pterm = rpt_pkg::ACC_W'($signed(pose.pos[r])) <<< rpt_pkg::COEF_FRAC;
            acc3_next[r] = rpt_pkg::ACC_W'(p2_reg[r*3])
                         + rpt_pkg::ACC_W'(p2_reg[r*3+1])
                         + rpt_pkg::ACC_W'(p2_reg[r*3+2])
                         + ((op2_reg == rpt_pkg::REQ_POINT) ? pterm : '0);
        end
    end

    // Stage 4: round half up, saturate, flag any clipped component
    always_comb begin
        logic signed [rpt_pkg::ACC_W-1:0] t;
        logic signed [RND_W-1:0]          q;
        rpt_pkg::vec_t                    res [3];
        logic                             clip [3];
        for (int r = 0; r < 3; r++) begin
            t = acc3_reg[r] + ACC_HALF;
            q = t[rpt_pkg::ACC_W-1:rpt_pkg::COEF_FRAC];
            clip[r] = !((q[RND_W-1:rpt_pkg::VEC_W-1] == {(RND_W-rpt_pkg::VEC_W+1){1'b0}})
                     || (q[RND_W-1:rpt_pkg::VEC_W-1] == {(RND_W-rpt_pkg::VEC_W+1){1'b1}}));
            if (!clip[r]) begin
                res[r] = q[rpt_pkg::VEC_W-1:0];
            end else if (q[RND_W-1]) begin
                res[r] = {1'b1, {(rpt_pkg::VEC_W-1){1'b0}}};
            end else begin
                res[r] = {1'b0, {(rpt_pkg::VEC_W-1){1'b1}}};
            end
        end
        out_next.out_x    = res[0];
        out_next.out_y    = res[1];
        out_next.out_z    = res[2];
        out_next.overflow = clip[0] || clip[1] || clip[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (en1) vld1_reg <= in_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
            if (en4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            v1_reg  <= v1_next;
            c1_reg  <= c1_next;
            op1_reg <= op_in;
        end
        if (en2 && vld1_reg) begin
            p2_reg  <= p2_next;
            op2_reg <= op1_reg;
        end
        if (en3 && vld2_reg) begin
            acc3_reg <= acc3_next;
        end
        if (en4 && vld3_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld4_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* src/rigid_pose_transform_unit.sv */
// Rigid pose transform unit: applies a quaternion pose to Q16.16 vectors.
//
// Channels: s_valid/s_ready/s_data take one request (operation code and
// vector) per transfer; m_valid/m_ready/m_data return one saturated vector
// with an overflow flag per request, in order. cfg_valid/cfg_ready with
// cfg_index and cfg_data write the pose registers (0..3 quaternion w,i,j,k;
// 4..6 position x,y,z); cfg_ready is always high.
// Throughput: one request per cycle while the receiver takes results and no
// matrix rebuild is pending. Results pass through four register stages.
// A quaternion write rebuilds the rotation matrix through the product
// register, then the entry register; s_ready is held low during the rebuild.
// Reset restores the identity rotation, zero position and empties the pipe.
// When the receiver stalls, results stay in the output register and the
// stages behind it keep filling bubbles before s_ready drops.
// Depends on rpt_pkg, rpt_cfg and rpt_pipe.
`default_nettype none

module rigid_pose_transform_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rpt_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rpt_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    rpt_pkg::pose_t pose;
    logic           pipe_valid;
    logic           pipe_ready;

    rpt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose)
    );

    // Hold off requests while the matrix is being rebuilt
    assign pipe_valid = s_valid && !pose.busy;
    assign s_ready    = pipe_ready && !pose.busy;

    rpt_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pipe_valid),
        .in_ready (pipe_ready),
        .in_data  (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .pose     (pose)
    );

endmodule

`default_nettype wire
